// ----- sv/fsci_pkg.sv -----
// ----------------------------------------------------------------------------
// fsci_pkg
// Shared types, constants and helpers of the friction and speed-cap
// integrator.
// ----------------------------------------------------------------------------
package fsci_pkg;

  localparam int unsigned VAL_W            = 32;
  localparam int unsigned ENTITY_LIMIT_DEF = 1024;
  localparam logic [15:0] GRIP_RESET       = 16'd256;
  localparam logic [9:0]  BOOST_RESET      = 10'd0;
  localparam int unsigned PCT_BASE         = 100;

  // ceil(2^45 / 25): x * RECIP_25 >> 45 equals x / 25 for any x below 2^40
  localparam logic [40:0] RECIP_25         = 41'd1407374883554;

  // register index on the configuration port
  typedef enum logic {
    REG_GRIP  = 1'b0,
    REG_BOOST = 1'b1
  } reg_idx_e;

  // per-item context carried down the pipeline
  typedef struct packed {
    logic             active;
    logic             boost;
    logic             cap;
    logic [15:0]      dt;
    logic [VAL_W-1:0] vx;
    logic [VAL_W-1:0] vy;
    logic [VAL_W-1:0] px;
    logic [VAL_W-1:0] py;
    logic [VAL_W-1:0] mx;
    logic [VAL_W-1:0] my;
    logic [39:0]      fcdt;
    logic [30:0]      maxs;
    logic [34:0]      lim;
    logic [VAL_W-1:0] f;
    logic [VAL_W-1:0] sp;
  } ctx_t;

  // magnitude of a signed 32-bit value (2^31 for the most negative)
  function automatic logic [VAL_W-1:0] abs32(input logic [VAL_W-1:0] v);
    abs32 = v[VAL_W-1] ? (~v + 32'd1) : v;
  endfunction

  // a +/- m with saturation to signed 32 bits
  function automatic logic [VAL_W-1:0] add_sat(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] m,
                                               input logic neg);
    logic [33:0] a34;
    logic [33:0] m34;
    logic [33:0] s;
    a34 = {{2{a[VAL_W-1]}}, a};
    m34 = {2'b00, m};
    s   = neg ? (a34 - m34) : (a34 + m34);
    if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
      add_sat = s[31:0];
    end else if (s[33]) begin
      add_sat = 32'h8000_0000;
    end else begin
      add_sat = 32'h7FFF_FFFF;
    end
  endfunction

  // magnitude below 1.0 in Q16.16
  function automatic logic below_one(input logic [VAL_W-1:0] v);
    below_one = (v[31:16] == 16'h0000) ||
                (v[31:16] == 16'hFFFF && v[15:0] != 16'h0000);
  endfunction

endpackage

// ----- sv/fsci_sqrt.sv -----
// ----------------------------------------------------------------------------
// fsci_sqrt
// Pipelined integer square root, one root bit per stage, with a tag that
// travels alongside.
// ----------------------------------------------------------------------------
module fsci_sqrt #(
  parameter int unsigned IN_W  = 64,
  parameter int unsigned TAG_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [IN_W-1:0]      rad_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 valid_o,
  output logic [IN_W/2-1:0]    root_o,
  output logic [TAG_W-1:0]     tag_o
);

  localparam int unsigned RT_W = IN_W / 2;

  logic [RT_W:0]    vld;
  logic [RT_W+1:0]  rem  [RT_W+1];
  logic [RT_W-1:0]  root [RT_W+1];
  logic [IN_W-1:0]  rad  [RT_W+1];
  logic [TAG_W-1:0] tag  [RT_W+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_i;
  assign tag[0]  = tag_i;

  for (genvar i = 0; i < RT_W; i++) begin : g_stage
    logic [RT_W+3:0] t;
    logic [RT_W+3:0] trial;
    logic [RT_W+3:0] diff;
    logic            ge;

    // one root bit: try subtracting 4*root+1
    always_comb begin
      t     = {rem[i], rad[i][IN_W-1:IN_W-2]};
      trial = {2'b00, root[i], 2'b01};
      diff  = t - trial;
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem[i+1]  <= ge ? diff[RT_W+1:0] : t[RT_W+1:0];
      root[i+1] <= {root[i][RT_W-2:0], ge};
      rad[i+1]  <= {rad[i][IN_W-3:0], 2'b00};
      tag[i+1]  <= tag[i];
    end
  end

  assign valid_o = vld[RT_W];
  assign root_o  = root[RT_W];
  assign tag_o   = tag[RT_W];

endmodule

// ----- sv/fsci_div.sv -----
// ----------------------------------------------------------------------------
// fsci_div
// Pipelined restoring divider, one quotient bit per stage. The upper
// NUM_W-QUO_W dividend bits must be below the divisor.
// ----------------------------------------------------------------------------
module fsci_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned QUO_W = 32,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [QUO_W:0]   vld;
  logic [DEN_W-1:0] rem [QUO_W+1];
  logic [QUO_W-1:0] nq  [QUO_W+1];
  logic [DEN_W-1:0] den [QUO_W+1];
  logic [TAG_W-1:0] tag [QUO_W+1];

  assign vld[0] = valid_i;
  assign rem[0] = DEN_W'(num_i[NUM_W-1:QUO_W]);
  assign nq[0]  = num_i[QUO_W-1:0];
  assign den[0] = den_i;
  assign tag[0] = tag_i;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      t    = {rem[i], nq[i][QUO_W-1]};
      diff = t - {1'b0, den[i]};
      ge   = (t >= {1'b0, den[i]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem[i+1] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      nq[i+1]  <= {nq[i][QUO_W-2:0], ge};
      den[i+1] <= den[i];
      tag[i+1] <= tag[i];
    end
  end

  assign valid_o = vld[QUO_W];
  assign quo_o   = nq[QUO_W];
  assign tag_o   = tag[QUO_W];

endmodule

// ----- sv/friction_speed_cap_integrator.sv -----
// ----------------------------------------------------------------------------
// friction_speed_cap_integrator
// Applies friction, small-speed zeroing, an optional speed cap and position
// integration to one body per transaction, in Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Pipeline: the path from the accepting edge to the result_valid_o pulse runs
// through two square roots and two divider pairs (32 stages each) and
// fourteen single register stages.
// Throughput: one transaction per cycle; busy stays low.
// Reset clears all valid bits and loads grip 1.0 and no boosted entity.
module friction_speed_cap_integrator #(
  parameter int unsigned ENTITY_LIMIT = fsci_pkg::ENTITY_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  entity_id_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [23:0] friction_coef_i,
  input  logic [30:0] max_speed_i,
  input  logic        speed_cap_on_i,
  input  logic [9:0]  damage_percent_i,
  input  logic [15:0] delta_time_i,
  output logic        result_valid_o,
  output logic [31:0] new_vel_x_o,
  output logic [31:0] new_vel_y_o,
  output logic [31:0] new_pos_x_o,
  output logic [31:0] new_pos_y_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CTX_W = $bits(fsci_pkg::ctx_t);

  // configuration registers
  logic [15:0] grip_q;
  logic [9:0]  boost_q;
  fsci_pkg::reg_idx_e cfg_idx;

  assign cfg_idx = fsci_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign prdata  = (cfg_idx == fsci_pkg::REG_BOOST) ? 32'(boost_q) : 32'(grip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grip_q  <= fsci_pkg::GRIP_RESET;
      boost_q <= fsci_pkg::BOOST_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        fsci_pkg::REG_GRIP:  grip_q  <= pwdata[15:0];
        fsci_pkg::REG_BOOST: boost_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // stage 1: capture, magnitudes, friction and limit products
  logic            v1_q;
  fsci_pkg::ctx_t  c1_d, c1_q;
  logic [41:0]     limp1_q;

  always_comb begin
    c1_d        = '0;
    c1_d.active = (entity_id_i != 10'd0) &&
                  (17'(entity_id_i) < 17'(ENTITY_LIMIT));
    c1_d.boost  = (boost_q != 10'd0) && (entity_id_i == boost_q);
    c1_d.cap    = speed_cap_on_i;
    c1_d.dt     = delta_time_i;
    c1_d.vx     = vel_x_i;
    c1_d.vy     = vel_y_i;
    c1_d.px     = pos_x_i;
    c1_d.py     = pos_y_i;
    c1_d.mx     = fsci_pkg::abs32(vel_x_i);
    c1_d.my     = fsci_pkg::abs32(vel_y_i);
    c1_d.fcdt   = 40'(friction_coef_i) * 40'(delta_time_i);
    c1_d.maxs   = max_speed_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q    <= c1_d;
    limp1_q <= 42'(max_speed_i) * (42'(damage_percent_i) + 42'(fsci_pkg::PCT_BASE));
  end

  // stage 2a: boosted limit is (product / 4) / 25, by reciprocal; partial products
  logic           v2a_q;
  fsci_pkg::ctx_t c2a_q;
  logic [39:0]    n4;
  logic [39:0]    pp_ac_q, pp_bc_q;
  logic [40:0]    pp_ad_q, pp_bd_q;

  assign n4 = limp1_q[41:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2a_q <= 1'b0;
    end else begin
      v2a_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c2a_q   <= c1_q;
    pp_ac_q <= 40'(n4[39:20]) * 40'(fsci_pkg::RECIP_25[40:21]);
    pp_ad_q <= 41'(n4[39:20]) * 41'(fsci_pkg::RECIP_25[20:0]);
    pp_bc_q <= 40'(n4[19:0]) * 40'(fsci_pkg::RECIP_25[40:21]);
    pp_bd_q <= 41'(n4[19:0]) * 41'(fsci_pkg::RECIP_25[20:0]);
  end

  // stage 2b: sum partial products, keep the bits above 2^45
  logic           v2_q;
  fsci_pkg::ctx_t c2_q;
  logic [79:0]    qsum2;
  logic [34:0]    q100_q;

  assign qsum2 = (80'(pp_ac_q) << 41) + (80'(pp_ad_q) << 20) +
                 (80'(pp_bc_q) << 21) + 80'(pp_bd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v2a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c2_q   <= c2a_q;
    q100_q <= qsum2[79:45];
  end

  // stage 3: squares, friction force, limit select
  logic           v3_q;
  fsci_pkg::ctx_t c3_d, c3_q;
  logic [63:0]    sqx3_q, sqy3_q;
  logic [55:0]    fp3;

  assign fp3 = 56'(c2_q.fcdt) * 56'(grip_q);

  always_comb begin
    c3_d     = c2_q;
    c3_d.f   = fp3[55:24];
    c3_d.lim = c2_q.boost ? q100_q : 35'(c2_q.maxs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c3_q   <= c3_d;
    sqx3_q <= 64'(c2_q.mx) * 64'(c2_q.mx);
    sqy3_q <= 64'(c2_q.my) * 64'(c2_q.my);
  end

  // stage 4: squared speed
  logic           v4_q;
  fsci_pkg::ctx_t c4_q;
  logic [63:0]    sum4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c4_q   <= c3_q;
    sum4_q <= sqx3_q + sqy3_q;
  end

  // speed before friction
  logic           vs1;
  logic [31:0]    sp1;
  fsci_pkg::ctx_t cs1;

  fsci_sqrt #(.IN_W(64), .TAG_W(CTX_W)) u_sqrt_pre (
    .clk_i, .rst_ni,
    .valid_i (v4_q),
    .rad_i   (sum4_q),
    .tag_i   (c4_q),
    .valid_o (vs1),
    .root_o  (sp1),
    .tag_o   (cs1)
  );

  // stage 5: friction numerators
  logic           v5_q;
  fsci_pkg::ctx_t c5_d, c5_q;
  logic [63:0]    prx5_q, pry5_q;
  logic           fric5_q;

  always_comb begin
    c5_d    = cs1;
    c5_d.sp = sp1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= vs1;
    end
  end

  always_ff @(posedge clk_i) begin
    c5_q    <= c5_d;
    fric5_q <= cs1.active && (sp1 != 32'd0);
    prx5_q  <= 64'(cs1.mx) * 64'(cs1.f);
    pry5_q  <= 64'(cs1.my) * 64'(cs1.f);
  end

  // friction share of each component
  logic           vd1, vd1y;
  logic [31:0]    qx1, qy1;
  fsci_pkg::ctx_t cd1;
  logic           fric_d1;

  fsci_div #(.NUM_W(64), .DEN_W(32), .QUO_W(32), .TAG_W(CTX_W)) u_div_fx (
    .clk_i, .rst_ni,
    .valid_i (v5_q),
    .num_i   (prx5_q),
    .den_i   (c5_q.sp),
    .tag_i   (c5_q),
    .valid_o (vd1),
    .quo_o   (qx1),
    .tag_o   (cd1)
  );

  fsci_div #(.NUM_W(64), .DEN_W(32), .QUO_W(32), .TAG_W(1)) u_div_fy (
    .clk_i, .rst_ni,
    .valid_i (v5_q),
    .num_i   (pry5_q),
    .den_i   (c5_q.sp),
    .tag_i   (fric5_q),
    .valid_o (vd1y),
    .quo_o   (qy1),
    .tag_o   (fric_d1)
  );

  // stage 6: apply friction, zero small components
  logic           v6_q;
  fsci_pkg::ctx_t c6_d, c6_q;
  logic [31:0]    fx6, fy6;

  always_comb begin
    fx6 = fsci_pkg::add_sat(cd1.vx, qx1, !cd1.vx[31]);
    fy6 = fsci_pkg::add_sat(cd1.vy, qy1, !cd1.vy[31]);
    if (fsci_pkg::below_one(fx6)) begin
      fx6 = '0;
    end
    if (fsci_pkg::below_one(fy6)) begin
      fy6 = '0;
    end
  end

  always_comb begin
    c6_d = cd1;
    if (fric_d1) begin
      c6_d.vx = fx6;
      c6_d.vy = fy6;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= vd1 && vd1y;
    end
  end

  always_ff @(posedge clk_i) begin
    c6_q <= c6_d;
  end

  // stage 7: magnitudes after friction
  logic           v7_q;
  fsci_pkg::ctx_t c7_d, c7_q;

  always_comb begin
    c7_d    = c6_q;
    c7_d.mx = fsci_pkg::abs32(c6_q.vx);
    c7_d.my = fsci_pkg::abs32(c6_q.vy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c7_q <= c7_d;
  end

  // stage 8: squares after friction
  logic           v8_q;
  fsci_pkg::ctx_t c8_q;
  logic [63:0]    sqx8_q, sqy8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c8_q   <= c7_q;
    sqx8_q <= 64'(c7_q.mx) * 64'(c7_q.mx);
    sqy8_q <= 64'(c7_q.my) * 64'(c7_q.my);
  end

  // stage 9: squared speed after friction
  logic           v9_q;
  fsci_pkg::ctx_t c9_q;
  logic [63:0]    sum9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else begin
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c9_q   <= c8_q;
    sum9_q <= sqx8_q + sqy8_q;
  end

  // speed after friction
  logic           vs2;
  logic [31:0]    sp2;
  fsci_pkg::ctx_t cs2;

  fsci_sqrt #(.IN_W(64), .TAG_W(CTX_W)) u_sqrt_post (
    .clk_i, .rst_ni,
    .valid_i (v9_q),
    .rad_i   (sum9_q),
    .tag_i   (c9_q),
    .valid_o (vs2),
    .root_o  (sp2),
    .tag_o   (cs2)
  );

  // stage 10: cap check and scale numerators
  logic           v10_q;
  fsci_pkg::ctx_t c10_d, c10_q;
  logic [63:0]    prx10_q, pry10_q;
  logic           need10_q;

  always_comb begin
    c10_d    = cs2;
    c10_d.sp = sp2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else begin
      v10_q <= vs2;
    end
  end

  always_ff @(posedge clk_i) begin
    c10_q    <= c10_d;
    need10_q <= cs2.active && cs2.cap && (35'(sp2) > cs2.lim);
    prx10_q  <= 64'(cs2.mx) * 64'(cs2.lim[31:0]);
    pry10_q  <= 64'(cs2.my) * 64'(cs2.lim[31:0]);
  end

  // scaled components
  logic           vd2, vd2y;
  logic [31:0]    qx2, qy2;
  fsci_pkg::ctx_t cd2;
  logic           need_d2;

  fsci_div #(.NUM_W(64), .DEN_W(32), .QUO_W(32), .TAG_W(CTX_W)) u_div_cx (
    .clk_i, .rst_ni,
    .valid_i (v10_q),
    .num_i   (prx10_q),
    .den_i   (c10_q.sp),
    .tag_i   (c10_q),
    .valid_o (vd2),
    .quo_o   (qx2),
    .tag_o   (cd2)
  );

  fsci_div #(.NUM_W(64), .DEN_W(32), .QUO_W(32), .TAG_W(1)) u_div_cy (
    .clk_i, .rst_ni,
    .valid_i (v10_q),
    .num_i   (pry10_q),
    .den_i   (c10_q.sp),
    .tag_i   (need10_q),
    .valid_o (vd2y),
    .quo_o   (qy2),
    .tag_o   (need_d2)
  );

  // stage 11: final velocity
  logic           v11_q;
  fsci_pkg::ctx_t c11_d, c11_q;

  always_comb begin
    c11_d = cd2;
    if (need_d2) begin
      c11_d.vx = cd2.vx[31] ? (~qx2 + 32'd1) : qx2;
      c11_d.vy = cd2.vy[31] ? (~qy2 + 32'd1) : qy2;
      c11_d.mx = qx2;
      c11_d.my = qy2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0;
    end else begin
      v11_q <= vd2 && vd2y;
    end
  end

  always_ff @(posedge clk_i) begin
    c11_q <= c11_d;
  end

  // stage 12: displacement magnitudes
  logic           v12_q;
  fsci_pkg::ctx_t c12_q;
  logic [47:0]    dpx12, dpy12;
  logic [31:0]    dx12_q, dy12_q;

  assign dpx12 = 48'(c11_q.mx) * 48'(c11_q.dt);
  assign dpy12 = 48'(c11_q.my) * 48'(c11_q.dt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q <= 1'b0;
    end else begin
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c12_q  <= c11_q;
    dx12_q <= dpx12[47:16];
    dy12_q <= dpy12[47:16];
  end

  // stage 13: position update, output registers
  logic        v13_q;
  logic [31:0] nvx13_q, nvy13_q, npx13_q, npy13_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v13_q <= 1'b0;
    end else begin
      v13_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nvx13_q <= c12_q.vx;
    nvy13_q <= c12_q.vy;
    npx13_q <= c12_q.active ? fsci_pkg::add_sat(c12_q.px, dx12_q, c12_q.vx[31])
                            : c12_q.px;
    npy13_q <= c12_q.active ? fsci_pkg::add_sat(c12_q.py, dy12_q, c12_q.vy[31])
                            : c12_q.py;
  end

  assign result_valid_o = v13_q;
  assign new_vel_x_o    = nvx13_q;
  assign new_vel_y_o    = nvy13_q;
  assign new_pos_x_o    = npx13_q;
  assign new_pos_y_o    = npy13_q;

endmodule
